>>> rtl/esos_pkg.sv
// ----------------------------------------------------------------------------
// esos_pkg
// Shared constants, types and opcodes of the elevator SCAN order scheduler.
// ----------------------------------------------------------------------------
package esos_pkg;

  // Number of floors served by the scheduler.
  localparam int FLOOR_COUNT = 4;
  // Bits needed to index one floor inside a request vector.
  localparam int FLOOR_IDX_W = (FLOOR_COUNT > 1) ? $clog2(FLOOR_COUNT) : 1;
  // Widths of the word fields.
  localparam int OPCODE_W = 3;
  localparam int FLOOR_W  = 4;

  typedef logic [FLOOR_COUNT-1:0] floor_vec_t;
  typedef logic [FLOOR_IDX_W-1:0] floor_idx_t;

  // Opcodes of an input word; six and seven are unused.
  typedef enum logic [OPCODE_W-1:0] {
    OP_ADD_UP    = 3'd0,
    OP_ADD_DOWN  = 3'd1,
    OP_ADD_DEST  = 3'd2,
    OP_CLEAR_ALL = 3'd3,
    OP_CLEAR_FLR = 3'd4,
    OP_QUERY     = 3'd5
  } op_t;

  // Start request from the control path to the scan unit.
  typedef struct packed {
    logic       start;
    floor_idx_t cur;
    logic       up;
  } scan_req_t;

  // Completion status from the scan unit.
  typedef struct packed {
    logic       done;
    logic       found;
    floor_idx_t floor_idx;
  } scan_res_t;

endpackage

>>> rtl/esos_if.sv
// ----------------------------------------------------------------------------
// esos_in_if / esos_out_if
// Valid/ready channels that carry input words and result words.
// ----------------------------------------------------------------------------
interface esos_in_if;
  import esos_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [FLOOR_W-1:0]  floor_number;
  logic                going_up;

  modport source (output valid, output opcode, output floor_number, output going_up,
                  input ready);
  modport sink (input valid, input opcode, input floor_number, input going_up,
                output ready);
endinterface

interface esos_out_if;
  import esos_pkg::*;

  logic               valid;
  logic               ready;
  logic [FLOOR_W-1:0] next_floor;
  logic               found;
  logic               bad_floor;

  modport source (output valid, output next_floor, output found, output bad_floor,
                  input ready);
  modport sink (input valid, input next_floor, input found, input bad_floor,
                output ready);
endinterface

>>> rtl/esos_scan.sv
// ----------------------------------------------------------------------------
// esos_scan
// Sequential SCAN search: one floor is tested per cycle by a single bit
// select and compare, walking three passes under a small sequencer.
// ----------------------------------------------------------------------------
module esos_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  esos_pkg::scan_req_t req,
  input  esos_pkg::floor_vec_t up_vec,
  input  esos_pkg::floor_vec_t down_vec,
  input  esos_pkg::floor_vec_t cabin_vec,
  output esos_pkg::scan_res_t res
);
  import esos_pkg::*;

  localparam floor_idx_t LAST_FLOOR = FLOOR_IDX_W'(FLOOR_COUNT - 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } scan_state_t;

  typedef enum logic [2:0] {
    PASS_FWD  = 3'b001,
    PASS_BACK = 3'b010,
    PASS_WRAP = 3'b100
  } pass_t;

  scan_state_t state_r, state_nxt;
  pass_t       pass_r, pass_nxt;
  floor_idx_t  flr_r, flr_nxt;
  floor_idx_t  cur_r, cur_nxt;
  logic        up_r, up_nxt;
  scan_res_t   res_r, res_nxt;

  floor_vec_t  hall_vec;
  logic        hit;
  logic        move_up;
  floor_idx_t  flr_step;
  floor_idx_t  far_end;
  floor_idx_t  near_end;

  // The floor under test and the step toward the current pass direction.
  always_comb begin
    priority if (pass_r == PASS_BACK) begin
      hall_vec = up_r ? down_vec : up_vec;
    end else begin
      hall_vec = up_r ? up_vec : down_vec;
    end
    hit      = hall_vec[flr_r] | cabin_vec[flr_r];
    move_up  = (pass_r == PASS_BACK) ? !up_r : up_r;
    flr_step = move_up ? (flr_r + 1'b1) : (flr_r - 1'b1);
    far_end  = up_r ? LAST_FLOOR : '0;
    near_end = up_r ? '0 : LAST_FLOOR;
  end

  // Sequencer: start on request, then test one floor per cycle until a hit or the last pass ends.
  always_comb begin
    state_nxt     = state_r;
    pass_nxt      = pass_r;
    flr_nxt       = flr_r;
    cur_nxt       = cur_r;
    up_nxt        = up_r;
    res_nxt       = res_r;
    res_nxt.done  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (req.start) begin
          state_nxt = S_RUN;
          pass_nxt  = PASS_FWD;
          flr_nxt   = req.cur;
          cur_nxt   = req.cur;
          up_nxt    = req.up;
        end
      end
      S_RUN: begin
        if (hit) begin
          state_nxt         = S_IDLE;
          res_nxt.done      = 1'b1;
          res_nxt.found     = 1'b1;
          res_nxt.floor_idx = flr_r;
        end else begin
          unique case (pass_r)
            PASS_FWD: begin
              if (flr_r == far_end) begin
                pass_nxt = PASS_BACK;
                flr_nxt  = far_end;
              end else begin
                flr_nxt = flr_step;
              end
            end
            PASS_BACK: begin
              if (flr_r == near_end) begin
                // The wrap pass is empty when the car sits at the near end.
                if (near_end == cur_r) begin
                  state_nxt         = S_IDLE;
                  res_nxt.done      = 1'b1;
                  res_nxt.found     = 1'b0;
                  res_nxt.floor_idx = '0;
                end else begin
                  pass_nxt = PASS_WRAP;
                  flr_nxt  = near_end;
                end
              end else begin
                flr_nxt = flr_step;
              end
            end
            PASS_WRAP: begin
              if (flr_step == cur_r) begin
                state_nxt         = S_IDLE;
                res_nxt.done      = 1'b1;
                res_nxt.found     = 1'b0;
                res_nxt.floor_idx = '0;
              end else begin
                flr_nxt = flr_step;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pass_r   <= PASS_FWD;
      res_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      pass_r   <= pass_nxt;
      res_r    <= res_nxt;
    end
    flr_r <= flr_nxt;
    cur_r <= cur_nxt;
    up_r  <= up_nxt;
  end

  assign res = res_r;

endmodule

>>> rtl/elevator_scan_order_scheduler_core.sv
// ----------------------------------------------------------------------------
// elevator_scan_order_scheduler_core
// Keeps hall-up, hall-down and cabin request vectors and answers SCAN queries.
// ----------------------------------------------------------------------------
// Each accepted word gives one result word. A non-query word is staged and moves
// to the output register once that is free; an in-range query first runs the scan
// unit, which tests at most 2 * FLOOR_COUNT floors, and then has its result staged.
// Throughput: one word at a time; in_chan.ready returns once the result is in
// the output register. Synchronous active-low reset clears all request vectors.
module elevator_scan_order_scheduler_core (
  input  logic clk,
  input  logic rst_n,
  esos_in_if.sink    in_chan,
  esos_out_if.source out_chan
);
  import esos_pkg::*;

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_SCAN = 3'b010,
    T_OUT  = 3'b100
  } top_state_t;

  top_state_t state_r, state_nxt;
  floor_vec_t up_r, up_nxt;
  floor_vec_t down_r, down_nxt;
  floor_vec_t cabin_r, cabin_nxt;

  logic [FLOOR_W-1:0] res_floor_r, res_floor_nxt;
  logic               res_found_r, res_found_nxt;
  logic               res_bad_r, res_bad_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [FLOOR_W-1:0] out_floor_r, out_floor_nxt;
  logic               out_found_r, out_found_nxt;
  logic               out_bad_r, out_bad_nxt;

  logic       accept;
  logic       floor_ok;
  floor_idx_t flr_idx;
  floor_vec_t flr_bit;
  scan_req_t  scan_req;
  scan_res_t  scan_res;

  assign accept   = in_chan.valid && in_chan.ready;
  assign floor_ok = {1'b0, in_chan.floor_number} < (FLOOR_W + 1)'(FLOOR_COUNT);
  assign flr_idx  = in_chan.floor_number[FLOOR_IDX_W-1:0];
  assign flr_bit  = floor_ok ? (floor_vec_t'(1) << flr_idx) : '0;

  // Scan unit that serves queries.
  esos_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (scan_req),
    .up_vec    (up_r),
    .down_vec  (down_r),
    .cabin_vec (cabin_r),
    .res       (scan_res)
  );

  // Word decode, request vector update, result staging and output register load.
  always_comb begin
    state_nxt      = state_r;
    up_nxt         = up_r;
    down_nxt       = down_r;
    cabin_nxt      = cabin_r;
    res_floor_nxt  = res_floor_r;
    res_found_nxt  = res_found_r;
    res_bad_nxt    = res_bad_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_floor_nxt  = out_floor_r;
    out_found_nxt  = out_found_r;
    out_bad_nxt    = out_bad_r;
    scan_req.start = 1'b0;
    scan_req.cur   = flr_idx;
    scan_req.up    = in_chan.going_up;
    unique case (state_r)
      T_IDLE: begin
        if (accept) begin
          res_floor_nxt = '0;
          res_found_nxt = 1'b0;
          res_bad_nxt   = 1'b0;
          state_nxt     = T_OUT;
          unique case (op_t'(in_chan.opcode))
            OP_ADD_UP: begin
              res_bad_nxt = !floor_ok;
              up_nxt      = up_r | flr_bit;
            end
            OP_ADD_DOWN: begin
              res_bad_nxt = !floor_ok;
              down_nxt    = down_r | flr_bit;
            end
            OP_ADD_DEST: begin
              res_bad_nxt = !floor_ok;
              cabin_nxt   = cabin_r | flr_bit;
            end
            OP_CLEAR_ALL: begin
              up_nxt    = '0;
              down_nxt  = '0;
              cabin_nxt = '0;
            end
            OP_CLEAR_FLR: begin
              res_bad_nxt = !floor_ok;
              up_nxt      = up_r & ~flr_bit;
              down_nxt    = down_r & ~flr_bit;
              cabin_nxt   = cabin_r & ~flr_bit;
            end
            OP_QUERY: begin
              res_bad_nxt = !floor_ok;
              if (floor_ok) begin
                scan_req.start = 1'b1;
                state_nxt      = T_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      T_SCAN: begin
        if (scan_res.done) begin
          res_found_nxt = scan_res.found;
          res_floor_nxt = FLOOR_W'(scan_res.floor_idx);
          state_nxt     = T_OUT;
        end
      end
      T_OUT: begin
        // Move the staged result into the output register when it is free.
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_floor_nxt = res_floor_r;
          out_found_nxt = res_found_r;
          out_bad_nxt   = res_bad_r;
          state_nxt     = T_IDLE;
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  // Registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      up_r        <= '0;
      down_r      <= '0;
      cabin_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      up_r        <= up_nxt;
      down_r      <= down_nxt;
      cabin_r     <= cabin_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_floor_r <= res_floor_nxt;
    res_found_r <= res_found_nxt;
    res_bad_r   <= res_bad_nxt;
    out_floor_r <= out_floor_nxt;
    out_found_r <= out_found_nxt;
    out_bad_r   <= out_bad_nxt;
  end

  assign in_chan.ready       = (state_r == T_IDLE);
  assign out_chan.valid      = out_valid_r;
  assign out_chan.next_floor = out_floor_r;
  assign out_chan.found      = out_found_r;
  assign out_chan.bad_floor  = out_bad_r;

endmodule

>>> rtl/esos_checker.sv
// ----------------------------------------------------------------------------
// esos_checker
// Port-level checks of the scheduler's handshakes and result words.
// ----------------------------------------------------------------------------
module esos_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [esos_pkg::FLOOR_W-1:0] out_next_floor,
  input logic                        out_found,
  input logic                        out_bad_floor
);
  import esos_pkg::*;

  // A result word that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // A word in progress blocks the next one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a word is in progress");

  // A found floor never comes with a bad floor flag, and lies inside the building.
  a_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |->
      !out_bad_floor && ({1'b0, out_next_floor} < (FLOOR_W + 1)'(FLOOR_COUNT)))
    else $error("found result with bad floor or floor out of range");

  // Without a hit the floor field reads zero.
  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_next_floor == '0)
    else $error("next_floor nonzero without a hit");

endmodule

bind elevator_scan_order_scheduler_core esos_checker u_esos_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_next_floor (out_chan.next_floor),
  .out_found      (out_chan.found),
  .out_bad_floor  (out_chan.bad_floor)
);

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the elevator SCAN order scheduler word by word. A directed table
// covers the field extremes, every opcode and the corner cases. Random traffic
// follows under three idling patterns with a long output hold-off and a full
// drain. Each result word is checked against a typed row's own answer or else
// a local predictor of the three request vectors and the SCAN search.
// ----------------------------------------------------------------------------
module tb;
  import esos_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 10;
  localparam int RAND_PER_PHASE = 167;
  localparam int RX_HOLD_CYCLES = 150;
  localparam int TAIL_CYCLES    = 3 * FLOOR_COUNT + 8;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int MAX_REPORTS    = 10;
  localparam int NO_STOP        = -1;
  localparam int DIR_ROWS       = 24;

  // Opcodes the block leaves unused.
  localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct {
    logic [FLOOR_W-1:0] next_floor;
    logic               found;
    logic               bad_floor;
  } answer_t;

  // One stimulus word; typed rows carry their expected answer.
  typedef struct {
    logic [OPCODE_W-1:0] op;
    logic [FLOOR_W-1:0]  fl;
    logic                up;
    bit                  typed;
    logic [FLOOR_W-1:0]  e_next;
    logic                e_found;
    logic                e_bad;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  esos_in_if  in_chan ();
  esos_out_if out_chan ();

  elevator_scan_order_scheduler_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #CLK_HALF clk = ~clk;

  // Predicted request vectors.
  floor_vec_t up_pend;
  floor_vec_t dn_pend;
  floor_vec_t cab_pend;

  answer_t answer_q[$];
  int      fail_count = 0;
  int      cycle_cnt = 0;
  int      tx_idle_pct = 23;
  int      rx_idle_pct = 49;
  bit      hold_tgl = 1'b0;
  bit      hold_seen = 1'b0;
  int      hold_left = 0;

  // Directed words: extremes, every opcode and the corner cases.
  stim_row_t dir_rows [DIR_ROWS] = '{
    '{OP_QUERY,     4'd0,  1'b1, 1'b1, 4'd0, 1'b0, 1'b0},  // nothing pending
    '{OP_QUERY,     4'd3,  1'b0, 1'b1, 4'd0, 1'b0, 1'b0},
    '{OP_ADD_UP,    4'd15, 1'b0, 1'b1, 4'd0, 1'b0, 1'b1},  // out-of-range floors
    '{OP_ADD_DOWN,  4'd4,  1'b1, 1'b1, 4'd0, 1'b0, 1'b1},
    '{OP_ADD_DEST,  4'd8,  1'b0, 1'b1, 4'd0, 1'b0, 1'b1},
    '{OP_CLEAR_FLR, 4'd15, 1'b1, 1'b1, 4'd0, 1'b0, 1'b1},
    '{OP_QUERY,     4'd15, 1'b1, 1'b1, 4'd0, 1'b0, 1'b1},
    '{OP_ADD_UP,    4'd0,  1'b0, 1'b1, 4'd0, 1'b0, 1'b0},
    '{OP_ADD_UP,    4'd0,  1'b1, 1'b1, 4'd0, 1'b0, 1'b0},  // already pending
    '{OP_ADD_DOWN,  4'd3,  1'b0, 1'b1, 4'd0, 1'b0, 1'b0},
    '{OP_ADD_DEST,  4'd2,  1'b1, 1'b1, 4'd0, 1'b0, 1'b0},
    '{OP_QUERY,     4'd1,  1'b1, 1'b0, 4'd0, 1'b0, 1'b0},
    '{OP_QUERY,     4'd3,  1'b1, 1'b0, 4'd0, 1'b0, 1'b0},
    '{OP_QUERY,     4'd1,  1'b0, 1'b0, 4'd0, 1'b0, 1'b0},
    '{OP_QUERY,     4'd0,  1'b0, 1'b0, 4'd0, 1'b0, 1'b0},
    '{OP_SPARE_6,   4'd15, 1'b1, 1'b1, 4'd0, 1'b0, 1'b0},  // unused opcodes
    '{OP_SPARE_7,   4'd0,  1'b0, 1'b1, 4'd0, 1'b0, 1'b0},
    '{OP_CLEAR_FLR, 4'd2,  1'b0, 1'b1, 4'd0, 1'b0, 1'b0},
    '{OP_QUERY,     4'd2,  1'b1, 1'b0, 4'd0, 1'b0, 1'b0},
    '{OP_CLEAR_ALL, 4'd15, 1'b1, 1'b1, 4'd0, 1'b0, 1'b0},  // floor is ignored
    '{OP_QUERY,     4'd3,  1'b1, 1'b1, 4'd0, 1'b0, 1'b0},
    '{OP_ADD_DOWN,  4'd1,  1'b1, 1'b1, 4'd0, 1'b0, 1'b0},
    '{OP_QUERY,     4'd3,  1'b1, 1'b0, 4'd0, 1'b0, 1'b0},
    '{OP_CLEAR_ALL, 4'd0,  1'b0, 1'b1, 4'd0, 1'b0, 1'b0}
  };

  // SCAN search over the predicted vectors; returns the stop or NO_STOP.
  function automatic int scan_for_stop(int cur, logic go_up);
    int         step;
    int         far_end;
    int         near_end;
    int         f;
    floor_vec_t with_dir;
    floor_vec_t against;
    step     = go_up ? 1 : -1;
    with_dir = go_up ? up_pend : dn_pend;
    against  = go_up ? dn_pend : up_pend;
    far_end  = go_up ? FLOOR_COUNT - 1 : 0;
    near_end = go_up ? 0 : FLOOR_COUNT - 1;
    // Ahead of the car in the travel direction.
    for (f = cur; f >= 0 && f < FLOOR_COUNT; f += step)
      if (with_dir[f] || cab_pend[f]) return f;
    // Back across the whole shaft for calls the other way.
    for (f = far_end; f >= 0 && f < FLOOR_COUNT; f -= step)
      if (against[f] || cab_pend[f]) return f;
    // From the near end up to the car, current floor excluded.
    for (f = near_end; f != cur && f >= 0 && f < FLOOR_COUNT; f += step)
      if (with_dir[f] || cab_pend[f]) return f;
    return NO_STOP;
  endfunction

  // Applies one word to the predicted vectors and returns its answer.
  function automatic answer_t predict_answer(logic [OPCODE_W-1:0] op,
                                             logic [FLOOR_W-1:0] fl, logic go_up);
    answer_t    a;
    logic       in_range;
    floor_vec_t sel;
    int         stop;
    a.next_floor = '0;
    a.found      = 1'b0;
    a.bad_floor  = 1'b0;
    in_range     = (fl < FLOOR_COUNT);
    sel          = in_range ? (floor_vec_t'(1) << fl) : '0;
    unique case (op)
      OP_ADD_UP: begin
        a.bad_floor = !in_range;
        up_pend |= sel;
      end
      OP_ADD_DOWN: begin
        a.bad_floor = !in_range;
        dn_pend |= sel;
      end
      OP_ADD_DEST: begin
        a.bad_floor = !in_range;
        cab_pend |= sel;
      end
      OP_CLEAR_ALL: begin
        up_pend  = '0;
        dn_pend  = '0;
        cab_pend = '0;
      end
      OP_CLEAR_FLR: begin
        a.bad_floor = !in_range;
        up_pend  &= ~sel;
        dn_pend  &= ~sel;
        cab_pend &= ~sel;
      end
      OP_QUERY: begin
        if (!in_range) begin
          a.bad_floor = 1'b1;
        end else begin
          stop = scan_for_stop(int'(fl), go_up);
          if (stop != NO_STOP) begin
            a.found      = 1'b1;
            a.next_floor = FLOOR_W'(stop);
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // Random word: mostly in-range floors, weighted toward adds and queries.
  function automatic stim_row_t random_word();
    stim_row_t r;
    int        pick;
    pick = $urandom_range(99);
    if (pick < 15)      r.op = OP_ADD_UP;
    else if (pick < 30) r.op = OP_ADD_DOWN;
    else if (pick < 45) r.op = OP_ADD_DEST;
    else if (pick < 75) r.op = OP_QUERY;
    else if (pick < 88) r.op = OP_CLEAR_FLR;
    else if (pick < 95) r.op = OP_CLEAR_ALL;
    else if (pick < 97) r.op = OP_SPARE_6;
    else                r.op = OP_SPARE_7;
    if ($urandom_range(99) < 88) r.fl = FLOOR_W'($urandom_range(FLOOR_COUNT - 1));
    else                         r.fl = FLOOR_W'($urandom_range(15, FLOOR_COUNT));
    r.up      = 1'($urandom_range(1));
    r.typed   = 1'b0;
    r.e_next  = '0;
    r.e_found = 1'b0;
    r.e_bad   = 1'b0;
    return r;
  endfunction

  // Offers one word, waits for its acceptance and records its answer.
  task automatic send_word(input stim_row_t r);
    answer_t a;
    in_chan.valid        <= 1'b1;
    in_chan.opcode       <= r.op;
    in_chan.floor_number <= r.fl;
    in_chan.going_up     <= r.up;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    a = predict_answer(r.op, r.fl, r.up);
    if (r.typed) begin
      a.next_floor = r.e_next;
      a.found      = r.e_found;
      a.bad_floor  = r.e_bad;
    end
    answer_q.push_back(a);
  endtask

  // Sender idling between words.
  task automatic maybe_idle();
    if ($urandom_range(99) < tx_idle_pct) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  // Output ready: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_tgl != hold_seen) begin
      hold_seen = hold_tgl;
      hold_left = RX_HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Result checker: each word against the oldest expected answer.
  always @(posedge clk) begin : result_check
    answer_t exp_a;
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (answer_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result word: next_floor=%0d found=%b bad_floor=%b",
                   out_chan.next_floor, out_chan.found, out_chan.bad_floor);
      end else begin
        exp_a = answer_q.pop_front();
        if (out_chan.next_floor !== exp_a.next_floor || out_chan.found !== exp_a.found ||
            out_chan.bad_floor !== exp_a.bad_floor) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("mismatch: expected next_floor=%0d found=%b bad_floor=%b, got %0d %b %b",
                     exp_a.next_floor, exp_a.found, exp_a.bad_floor,
                     out_chan.next_floor, out_chan.found, out_chan.bad_floor);
        end
      end
    end
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("elevator_scan_order_scheduler_core verification failed");
    $finish;
  end

  // Main sequence: reset, directed table, then three random phases.
  initial begin : stimulus
    int phase;
    int i;
    in_chan.valid        = 1'b0;
    in_chan.opcode       = OP_ADD_UP;
    in_chan.floor_number = '0;
    in_chan.going_up     = 1'b0;
    up_pend  = '0;
    dn_pend  = '0;
    cab_pend = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < DIR_ROWS; i++) begin
      maybe_idle();
      send_word(dir_rows[i]);
    end

    for (phase = 0; phase < 3; phase++) begin
      unique case (phase)
        0: begin tx_idle_pct = 23; rx_idle_pct = 49; end
        1: begin tx_idle_pct = 49; rx_idle_pct = 23; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (i = 0; i < RAND_PER_PHASE; i++) begin
        // Long output hold-off while words keep coming.
        if (phase == 0 && i == 40) hold_tgl = ~hold_tgl;
        // Full drain before going on.
        if (phase == 1 && i == 60) begin
          in_chan.valid <= 1'b0;
          wait (answer_q.size() == 0);
          @(posedge clk);
        end
        maybe_idle();
        send_word(random_word());
      end
    end
    in_chan.valid <= 1'b0;

    wait (answer_q.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && answer_q.size() == 0) begin
      $display("elevator_scan_order_scheduler_core verification clean");
    end else begin
      $display("elevator_scan_order_scheduler_core verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/esos_pkg.sv
rtl/esos_if.sv
rtl/esos_scan.sv
rtl/elevator_scan_order_scheduler_core.sv
rtl/esos_checker.sv
tb/sv/tb.sv
